>>> src/rup_clause_proof_checker_assert.svh
`ifndef RUP_CLAUSE_PROOF_CHECKER_ASSERT_SVH
`define RUP_CLAUSE_PROOF_CHECKER_ASSERT_SVH
// Assertion that an implication holds on every clock edge out of reset.
`define RUP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Assertion that an implication holds in the cycle after its antecedent.
`define RUP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> src/rup_pkg.sv
package rup_pkg;

    localparam int MaxVarsDef      = 1024;
    localparam int MaxClausesDef   = 4096;
    localparam int MaxClauseLenDef = 32;
    localparam int LitW            = 12;
    localparam int CfgW            = 11;

    localparam logic [1:0] OP_ORIG = 2'd0;
    localparam logic [1:0] OP_LEMMA = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;
    localparam logic [1:0] OP_END  = 2'd3;

    localparam logic [3:0] ST_ADDED   = 4'd0;
    localparam logic [3:0] ST_LEMMA   = 4'd1;
    localparam logic [3:0] ST_RUPFAIL = 4'd2;
    localparam logic [3:0] ST_DELETED = 4'd3;
    localparam logic [3:0] ST_ABSENT  = 4'd4;
    localparam logic [3:0] ST_DUP     = 4'd5;
    localparam logic [3:0] ST_TAUT    = 4'd6;
    localparam logic [3:0] ST_RANGE   = 4'd7;
    localparam logic [3:0] ST_AFTER   = 4'd8;
    localparam logic [3:0] ST_FULL    = 4'd9;
    localparam logic [3:0] ST_LONG    = 4'd10;
    localparam logic [3:0] ST_DONE    = 4'd11;
    localparam logic [3:0] ST_NOEMPTY = 4'd12;

    typedef struct packed {
        logic [1:0]             opcode;
        logic signed [LitW-1:0] literal;
        logic                   literal_present;
        logic                   last;
    } in_item_t;

    typedef struct packed {
        logic [3:0] status;
        logic       empty_derived;
    } out_item_t;

    // Command from the front part to the back part.
    typedef struct packed {
        logic [1:0] opcode;
        logic       too_long;
    } cmd_t;

endpackage

>>> src/rup_front.sv
module rup_front
    import rup_pkg::*;
#(
    parameter int MAX_CLAUSE_LEN = MaxClauseLenDef,
    parameter int LW = $clog2(MAX_CLAUSE_LEN + 2)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   q_valid,
    input  logic                   q_ready,
    output cmd_t                   q_cmd,
    output logic [LW-1:0]          q_len,
    input  logic [$clog2(MAX_CLAUSE_LEN)-1:0] rd_idx,
    output logic signed [LitW-1:0] rd_lit
);
    localparam int IW = $clog2(MAX_CLAUSE_LEN);

    logic signed [LitW-1:0] stage_reg [MAX_CLAUSE_LEN];
    logic [LW-1:0] cnt_reg;
    logic          qv_reg;
    cmd_t          cmd_reg;
    logic [LW-1:0] len_reg;

    // Staging is held while the back part owns a closed clause.
    assign s_ready = !qv_reg;
    assign q_valid = qv_reg;
    assign q_cmd   = cmd_reg;
    assign q_len   = len_reg;
    assign rd_lit  = stage_reg[rd_idx];

    // Stage literals and hand closed clauses to the back part.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            qv_reg  <= 1'b0;
        end else begin
            if (qv_reg && q_ready) begin
                qv_reg  <= 1'b0;
                cnt_reg <= '0;
            end
            if (s_valid && s_ready) begin
                if (s_data.opcode == OP_END) begin
                    cnt_reg <= '0;
                    qv_reg  <= 1'b1;
                    cmd_reg <= '{opcode: OP_END, too_long: 1'b0};
                end else begin
                    if (s_data.literal_present) begin
                        if (cnt_reg < LW'(MAX_CLAUSE_LEN)) begin
                            stage_reg[cnt_reg[IW-1:0]] <= s_data.literal;
                            cnt_reg <= cnt_reg + 1'b1;
                        end else begin
                            cnt_reg <= LW'(MAX_CLAUSE_LEN + 1);
                        end
                    end
                    if (s_data.last) begin
                        qv_reg <= 1'b1;
                        cmd_reg.opcode <= s_data.opcode;
                        cmd_reg.too_long <= (cnt_reg > LW'(MAX_CLAUSE_LEN)) ||
                            (s_data.literal_present && cnt_reg == LW'(MAX_CLAUSE_LEN));
                        len_reg <= (s_data.literal_present &&
                                    cnt_reg < LW'(MAX_CLAUSE_LEN)) ?
                                   cnt_reg + 1'b1 : cnt_reg;
                    end
                end
            end
        end
    end
endmodule

>>> src/rup_back.sv
module rup_back
    import rup_pkg::*;
#(
    parameter int MAX_VARS = MaxVarsDef,
    parameter int MAX_CLAUSES = MaxClausesDef,
    parameter int MAX_CLAUSE_LEN = MaxClauseLenDef,
    parameter int LW = $clog2(MAX_CLAUSE_LEN + 2)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [CfgW-1:0]        variable_limit,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  cmd_t                   q_cmd,
    input  logic [LW-1:0]          q_len,
    output logic [$clog2(MAX_CLAUSE_LEN)-1:0] rd_idx,
    input  logic signed [LitW-1:0] rd_lit,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data
);
    localparam int IW = $clog2(MAX_CLAUSE_LEN);
    localparam int CW = $clog2(MAX_CLAUSES + 1);
    localparam int AW = $clog2(MAX_CLAUSES);
    localparam int VW = $clog2(MAX_VARS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_RANGE, S_SORT_RD, S_SORT_CMP, S_DUP, S_SCAN_ASG, S_TAUT,
        S_CLR, S_ASGN, S_FIND, S_FIND_LIT, S_FIND_CMP, S_OP, S_WRITE,
        S_SCAN, S_SCAN_LIT, S_SCAN_EVAL, S_SCAN_END, S_CNT_RD, S_CNT_WR, S_OUT
    } state_t;

    // Local sorted copy of the clause, small and register based.
    logic signed [LitW-1:0] cl_reg [MAX_CLAUSE_LEN];
    // Clause memories.
    logic signed [LitW-1:0] lit_mem [MAX_CLAUSES*MAX_CLAUSE_LEN];
    logic [LW-1:0]          len_mem [MAX_CLAUSES];
    logic [31:0]            cnt_mem [MAX_CLAUSES];
    logic [1:0]             asg_mem [MAX_VARS+1];

    state_t        st_reg;
    logic [LW-1:0] n_reg;
    logic [LW-1:0] i_reg, j_reg;
    logic [CW-1:0] total_reg, ci_reg;
    logic          empty_reg, mv_reg, changed_reg, sat_reg, mis_reg;
    logic [3:0]    status_reg;
    out_item_t     out_reg;
    logic [LW-1:0] free_reg, len_rd_reg;
    logic signed [LitW-1:0] unit_reg, lit_rd_reg;
    logic [31:0]   cnt_rd_reg;
    logic [1:0]    asg_rd_reg;
    logic [VW-1:0] clr_reg;
    logic [10:0]   limit;
    logic [LitW-1:0] av;
    logic [1:0]      lit_val;

    function automatic logic [LitW-1:0] absval(input logic signed [LitW-1:0] x);
        absval = x[LitW-1] ? LitW'(-x) : x;
    endfunction

    assign q_ready = (st_reg == S_OUT) && (!mv_reg || m_ready);
    assign rd_idx  = i_reg[IW-1:0];
    assign m_valid = mv_reg;
    assign m_data  = out_reg;
    assign limit   = (q_cmd.opcode == OP_ORIG && 32'(variable_limit) < MAX_VARS) ?
                     variable_limit : 11'(MAX_VARS > 2047 ? 2047 : MAX_VARS);

    assign av = absval(lit_rd_reg);
    assign lit_val = lit_rd_reg[LitW-1] ? 2'b10 : 2'b01;

    // Sequencer: checks, store lookup, propagation passes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_IDLE;
            total_reg <= '0;
            empty_reg <= 1'b0;
            mv_reg    <= 1'b0;
            out_reg   <= '0;
        end else begin
            if (mv_reg && m_ready) mv_reg <= 1'b0;
            case (st_reg)
                S_IDLE: if (q_valid) begin
                    n_reg <= q_len;
                    i_reg <= '0;
                    if (q_cmd.opcode == OP_END) begin
                        status_reg <= empty_reg ? ST_DONE : ST_NOEMPTY;
                        st_reg <= S_OUT;
                    end else if (empty_reg) begin
                        status_reg <= ST_AFTER; st_reg <= S_OUT;
                    end else if (q_cmd.too_long) begin
                        status_reg <= ST_LONG; st_reg <= S_OUT;
                    end else st_reg <= S_LOAD;
                end
                // Copy the clause and check ranges, one literal a cycle.
                S_LOAD: begin
                    if (i_reg == n_reg) begin
                        i_reg <= LW'(1); st_reg <= S_SORT_RD;
                    end else begin
                        cl_reg[i_reg[IW-1:0]] <= rd_lit;
                        if (absval(rd_lit) == '0 ||
                            32'(absval(rd_lit)) > 32'(limit)) begin
                            status_reg <= ST_RANGE; st_reg <= S_OUT;
                        end
                        i_reg <= i_reg + 1'b1;
                    end
                end
                // Insertion sort: one compare and swap a cycle.
                S_SORT_RD: begin
                    if (i_reg >= n_reg) begin
                        i_reg <= LW'(1); st_reg <= S_DUP;
                    end else begin
                        j_reg <= i_reg; st_reg <= S_SORT_CMP;
                    end
                end
                S_SORT_CMP: begin
                    if (j_reg != '0 && cl_reg[IW'(j_reg - 1'b1)] > cl_reg[j_reg[IW-1:0]]) begin
                        cl_reg[IW'(j_reg - 1'b1)] <= cl_reg[j_reg[IW-1:0]];
                        cl_reg[j_reg[IW-1:0]] <= cl_reg[IW'(j_reg - 1'b1)];
                        j_reg <= j_reg - 1'b1;
                    end else begin
                        i_reg <= i_reg + 1'b1; st_reg <= S_SORT_RD;
                    end
                end
                S_DUP: begin
                    if (i_reg >= n_reg) begin
                        i_reg <= '0; j_reg <= '0; st_reg <= S_TAUT;
                    end else if (cl_reg[i_reg[IW-1:0]] == cl_reg[IW'(i_reg - 1'b1)]) begin
                        status_reg <= ST_DUP; st_reg <= S_OUT;
                    end else i_reg <= i_reg + 1'b1;
                end
                // Tautology: all pairs, one a cycle.
                S_TAUT: begin
                    if (i_reg >= n_reg) begin
                        ci_reg <= '0;
                        if (q_cmd.opcode == OP_LEMMA) begin
                            clr_reg <= '0; st_reg <= S_CLR;
                        end else st_reg <= S_FIND;
                    end else begin
                        if (cl_reg[j_reg[IW-1:0]] == -cl_reg[i_reg[IW-1:0]]) begin
                            status_reg <= ST_TAUT; st_reg <= S_OUT;
                        end
                        if (j_reg + 1'b1 >= n_reg) begin
                            j_reg <= '0; i_reg <= i_reg + 1'b1;
                        end else j_reg <= j_reg + 1'b1;
                    end
                end
                // Clear the assignment table, one entry a cycle.
                S_CLR: begin
                    asg_mem[clr_reg] <= 2'b00;
                    if (32'(clr_reg) == MAX_VARS) begin
                        i_reg <= '0; st_reg <= S_ASGN;
                    end else clr_reg <= clr_reg + 1'b1;
                end
                // Assign the negated lemma literals.
                S_ASGN: begin
                    if (i_reg >= n_reg) begin
                        ci_reg <= '0; changed_reg <= 1'b0; st_reg <= S_SCAN;
                    end else begin
                        asg_mem[VW'(absval(cl_reg[i_reg[IW-1:0]]))] <=
                            cl_reg[i_reg[IW-1:0]][LitW-1] ? 2'b01 : 2'b10;
                        i_reg <= i_reg + 1'b1;
                    end
                end
                // Propagation pass over all clauses.
                S_SCAN: begin
                    if (ci_reg == total_reg) begin
                        if (changed_reg) begin
                            ci_reg <= '0; changed_reg <= 1'b0;
                        end else begin
                            status_reg <= ST_RUPFAIL; st_reg <= S_OUT;
                        end
                    end else begin
                        cnt_rd_reg <= cnt_mem[ci_reg[AW-1:0]];
                        len_rd_reg <= len_mem[ci_reg[AW-1:0]];
                        j_reg <= '0; free_reg <= '0; sat_reg <= 1'b0;
                        st_reg <= S_SCAN_LIT;
                    end
                end
                S_SCAN_LIT: begin
                    if (cnt_rd_reg == '0 || sat_reg || j_reg == len_rd_reg) begin
                        st_reg <= S_SCAN_END;
                    end else begin
                        lit_rd_reg <= lit_mem[{ci_reg[AW-1:0], j_reg[IW-1:0]}];
                        st_reg <= S_SCAN_ASG;
                    end
                end
                // Fetch the assignment of the literal's variable.
                S_SCAN_ASG: begin
                    asg_rd_reg <= asg_mem[VW'(av)];
                    st_reg <= S_SCAN_EVAL;
                end
                S_SCAN_EVAL: begin
                    if (asg_rd_reg == 2'b00) begin
                        free_reg <= free_reg + 1'b1; unit_reg <= lit_rd_reg;
                    end else if (asg_rd_reg == lit_val) sat_reg <= 1'b1;
                    j_reg <= j_reg + 1'b1;
                    st_reg <= S_SCAN_LIT;
                end
                S_SCAN_END: begin
                    st_reg <= S_SCAN;
                    ci_reg <= ci_reg + 1'b1;
                    if (cnt_rd_reg != '0 && !sat_reg) begin
                        if (free_reg == '0) begin
                            ci_reg <= '0; st_reg <= S_FIND;
                        end else if (free_reg == LW'(1)) begin
                            asg_mem[VW'(absval(unit_reg))] <=
                                unit_reg[LitW-1] ? 2'b10 : 2'b01;
                            changed_reg <= 1'b1;
                        end
                    end
                end
                // Look up the clause in the store, one literal at a time.
                S_FIND: begin
                    if (ci_reg == total_reg) st_reg <= S_OP;
                    else begin
                        len_rd_reg <= len_mem[ci_reg[AW-1:0]];
                        j_reg <= '0; mis_reg <= 1'b0;
                        st_reg <= S_FIND_LIT;
                    end
                end
                S_FIND_LIT: begin
                    if (len_rd_reg != n_reg || mis_reg) begin
                        ci_reg <= ci_reg + 1'b1; st_reg <= S_FIND;
                    end else if (j_reg == n_reg) begin
                        st_reg <= S_CNT_RD;
                    end else begin
                        lit_rd_reg <= lit_mem[{ci_reg[AW-1:0], j_reg[IW-1:0]}];
                        st_reg <= S_FIND_CMP;
                    end
                end
                S_FIND_CMP: begin
                    if (lit_rd_reg != cl_reg[j_reg[IW-1:0]]) mis_reg <= 1'b1;
                    j_reg <= j_reg + 1'b1;
                    st_reg <= S_FIND_LIT;
                end
                S_CNT_RD: begin
                    cnt_rd_reg <= cnt_mem[ci_reg[AW-1:0]];
                    st_reg <= S_CNT_WR;
                end
                // Update the copy count of a matching clause.
                S_CNT_WR: begin
                    st_reg <= S_OUT;
                    if (q_cmd.opcode == OP_DEL) begin
                        if (cnt_rd_reg == '0) status_reg <= ST_ABSENT;
                        else begin
                            cnt_mem[ci_reg[AW-1:0]] <= cnt_rd_reg - 1'b1;
                            status_reg <= ST_DELETED;
                        end
                    end else begin
                        if (cnt_rd_reg != '1)
                            cnt_mem[ci_reg[AW-1:0]] <= cnt_rd_reg + 1'b1;
                        status_reg <= (q_cmd.opcode == OP_LEMMA) ? ST_LEMMA : ST_ADDED;
                        if (q_cmd.opcode == OP_LEMMA && n_reg == '0) empty_reg <= 1'b1;
                    end
                end
                // No match in the store.
                S_OP: begin
                    if (q_cmd.opcode == OP_DEL) begin
                        status_reg <= ST_ABSENT; st_reg <= S_OUT;
                    end else if (32'(total_reg) >= MAX_CLAUSES) begin
                        status_reg <= ST_FULL; st_reg <= S_OUT;
                    end else begin
                        len_mem[total_reg[AW-1:0]] <= n_reg;
                        cnt_mem[total_reg[AW-1:0]] <= 32'd1;
                        j_reg <= '0; st_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (j_reg == n_reg) begin
                        total_reg <= total_reg + 1'b1;
                        status_reg <= (q_cmd.opcode == OP_LEMMA) ? ST_LEMMA : ST_ADDED;
                        if (q_cmd.opcode == OP_LEMMA && n_reg == '0) empty_reg <= 1'b1;
                        st_reg <= S_OUT;
                    end else begin
                        lit_mem[{total_reg[AW-1:0], j_reg[IW-1:0]}] <= cl_reg[j_reg[IW-1:0]];
                        j_reg <= j_reg + 1'b1;
                    end
                end
                // Load the result register once the previous beat is gone.
                S_OUT: if (!mv_reg || m_ready) begin
                    mv_reg <= 1'b1; st_reg <= S_IDLE;
                    out_reg <= '{status: status_reg, empty_derived: empty_reg};
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> src/rup_clause_proof_checker.sv
// Channel | Ports                        | Beat
// input   | s_valid, s_ready, s_data     | one literal with opcode and last flag
// result  | m_valid, m_ready, m_data     | status and empty_derived per clause
// config  | cfg_we, cfg_data             | variable_limit, written at once
// Literal beats are taken while no closed clause is pending; a closed clause holds the input until done.
// Checks cover ranges, the insertion sort, duplicates and tautologies; a store
// lookup visits every stored clause and compares the literals of each stored
// clause of the same length; a lemma adds a clear of all MAX_VARS+1 assignment
// entries and propagation passes that read every stored clause and its literals.
// Reset is synchronous, active low; the stores hold no reset.
module rup_clause_proof_checker
    import rup_pkg::*;
#(
    parameter int MAX_VARS = MaxVarsDef,
    parameter int MAX_CLAUSES = MaxClausesDef,
    parameter int MAX_CLAUSE_LEN = MaxClauseLenDef
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CfgW-1:0]  cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);
`include "rup_clause_proof_checker_assert.svh"
    localparam int LW = $clog2(MAX_CLAUSE_LEN + 2);

    logic [CfgW-1:0] vlim_reg;
    logic q_valid, q_ready;
    cmd_t q_cmd;
    logic [LW-1:0] q_len;
    logic [$clog2(MAX_CLAUSE_LEN)-1:0] rd_idx;
    logic signed [LitW-1:0] rd_lit;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) vlim_reg <= CfgW'(1024);
        else if (cfg_we) vlim_reg <= cfg_data;
    end

    rup_front #(.MAX_CLAUSE_LEN(MAX_CLAUSE_LEN), .LW(LW)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid, .q_ready, .q_cmd, .q_len, .rd_idx, .rd_lit
    );

    rup_back #(.MAX_VARS(MAX_VARS), .MAX_CLAUSES(MAX_CLAUSES),
               .MAX_CLAUSE_LEN(MAX_CLAUSE_LEN), .LW(LW)) u_back (
        .aclk, .aresetn, .variable_limit(vlim_reg),
        .q_valid, .q_ready, .q_cmd, .q_len, .rd_idx, .rd_lit,
        .m_valid, .m_ready, .m_data
    );

    `RUP_ASSERT_NEXT(a_hold_q, aclk, aresetn, q_valid && !q_ready, q_valid, "clause lost")
    `RUP_ASSERT_IMP(a_no_take, aclk, aresetn, q_valid, !s_ready, "input taken while busy")
    `RUP_ASSERT_NEXT(a_empty_sticky, aclk, aresetn, m_data.empty_derived, m_data.empty_derived, "empty flag dropped")
endmodule

>>> dv/rup_clause_proof_checker_test.sv
`timescale 1ns / 1ps

module rup_clause_proof_checker_test;
    import rup_pkg::*;

    localparam int NVARS = MaxVarsDef;
    localparam int NCLAUSES = MaxClausesDef;
    localparam int NLEN = MaxClauseLenDef;
    localparam int CYCLE_LIMIT = 800000;
    localparam int SETTLE_CYCLES = 3000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_we = 1'b0;
    logic [CfgW-1:0] cfg_data = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    rup_clause_proof_checker DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    // Stimulus beats waiting to be sent and verdicts waiting to arrive.
    in_item_t  pending_beats[$];
    out_item_t expected_verdicts[$];
    int        errors = 0;
    int        cycles = 0;
    bit        quiet = 1'b0;
    int        send_gap = 0;
    int        stall_gap = 0;

    // Shadow copy of the clause database and checker state.
    int          lit_store[NCLAUSES][NLEN];
    int          len_store[NCLAUSES];
    int unsigned copies[NCLAUSES];
    int          clause_count = 0;
    int          assign_tab[NVARS+1];
    int          staged[NLEN];
    int          staged_n = 0;
    bit          empty_seen = 1'b0;
    int unsigned var_limit = 1024;

    // Encoded clauses already sent, kept for deletions and repeats.
    int sent_clauses[$];

    function automatic int var_of(int x);
        return x < 0 ? -x : x;
    endfunction

    function automatic int find_clause(int n);
        bit same;
        for (int i = 0; i < clause_count; i++) begin
            if (len_store[i] == n) begin
                same = 1'b1;
                for (int k = 0; k < n; k++)
                    if (lit_store[i][k] != staged[k]) same = 1'b0;
                if (same) return i;
            end
        end
        return clause_count;
    endfunction

    function automatic bit store_clause(int n);
        int idx;
        idx = find_clause(n);
        if (idx < clause_count) begin
            if (copies[idx] != 32'hFFFF_FFFF) copies[idx]++;
            return 1'b1;
        end
        if (clause_count >= NCLAUSES) return 1'b0;
        for (int k = 0; k < n; k++) lit_store[clause_count][k] = staged[k];
        len_store[clause_count] = n;
        copies[clause_count] = 1;
        clause_count++;
        return 1'b1;
    endfunction

    // Reverse unit propagation: assign the negated lemma, then rescan to fixpoint.
    function automatic bit propagates_to_conflict(int n);
        bit changed, sat;
        int free_count, unit, v, c;
        for (int i = 0; i <= NVARS; i++) assign_tab[i] = 0;
        for (int k = 0; k < n; k++) assign_tab[var_of(staged[k])] = staged[k] > 0 ? -1 : 1;
        changed = 1'b1;
        while (changed) begin
            changed = 1'b0;
            for (int i = 0; i < clause_count; i++) begin
                if (copies[i] == 0) continue;
                free_count = 0;
                unit = 0;
                sat = 1'b0;
                for (int k = 0; k < len_store[i]; k++) begin
                    c = lit_store[i][k];
                    v = assign_tab[var_of(c)];
                    if (v == 0) begin
                        free_count++;
                        unit = c;
                    end else if ((v > 0) == (c > 0)) begin
                        sat = 1'b1;
                        break;
                    end
                end
                if (sat) continue;
                if (free_count == 0) return 1'b1;
                if (free_count == 1) begin
                    assign_tab[var_of(unit)] = unit > 0 ? 1 : -1;
                    changed = 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Verdict for a clause closed under the given opcode.
    function automatic logic [3:0] clause_verdict(logic [1:0] op);
        int n, lim, v, t, idx;
        n = staged_n;
        if (empty_seen) return ST_AFTER;
        if (n > NLEN) return ST_LONG;
        lim = NVARS;
        if (op == OP_ORIG && var_limit < lim) lim = var_limit;
        for (int i = 0; i < n; i++) begin
            v = var_of(staged[i]);
            if (v == 0 || v > lim) return ST_RANGE;
        end
        for (int i = 1; i < n; i++)
            for (int j = i; j > 0 && staged[j-1] > staged[j]; j--) begin
                t = staged[j];
                staged[j] = staged[j-1];
                staged[j-1] = t;
            end
        for (int i = 1; i < n; i++)
            if (staged[i] == staged[i-1]) return ST_DUP;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (staged[j] == -staged[i]) return ST_TAUT;
        if (op == OP_ORIG) return store_clause(n) ? ST_ADDED : ST_FULL;
        if (op == OP_LEMMA) begin
            if (!propagates_to_conflict(n)) return ST_RUPFAIL;
            if (!store_clause(n)) return ST_FULL;
            if (n == 0) empty_seen = 1'b1;
            return ST_LEMMA;
        end
        idx = find_clause(n);
        if (idx >= clause_count || copies[idx] == 0) return ST_ABSENT;
        copies[idx]--;
        return ST_DELETED;
    endfunction

    // Advance the shadow state by one accepted beat.
    task automatic predict_beat(in_item_t it);
        out_item_t res;
        int lit;
        lit = it.literal;
        if (it.opcode == OP_END) begin
            staged_n = 0;
            res.status = empty_seen ? ST_DONE : ST_NOEMPTY;
            res.empty_derived = empty_seen;
            expected_verdicts.insert(expected_verdicts.size(), res);
            return;
        end
        if (it.literal_present) begin
            if (staged_n < NLEN) staged[staged_n++] = lit;
            else staged_n = NLEN + 1;
        end
        if (!it.last) return;
        res.status = clause_verdict(it.opcode);
        staged_n = 0;
        res.empty_derived = empty_seen;
        expected_verdicts.insert(expected_verdicts.size(), res);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    task automatic push_beat(logic [1:0] op, int lit, bit present, bit last);
        in_item_t it;
        it.opcode = op;
        it.literal = lit[LitW-1:0];
        it.literal_present = present;
        it.last = last;
        pending_beats.insert(pending_beats.size(), it);
    endtask

    // Clause of up to three small literals, or the empty clause when n is 0.
    task automatic push_clause(logic [1:0] op, int n, int a, int b, int c);
        int lits[3];
        lits = '{a, b, c};
        if (n == 0) push_beat(op, 0, 1'b0, 1'b1);
        for (int k = 0; k < n; k++) push_beat(op, lits[k], 1'b1, k == n - 1);
    endtask

    task automatic push_long_clause(logic [1:0] op, int n);
        for (int k = 0; k < n; k++) push_beat(op, k + 1, 1'b1, k == n - 1);
    endtask

    task automatic write_limit(int unsigned v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_data <= v[CfgW-1:0];
        var_limit = v & 32'h7FF;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Block until every beat is sent, every verdict is in, and the block settles.
    task automatic wait_idle();
        wait (pending_beats.size() == 0 && !s_valid && expected_verdicts.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic int rand_lit(int nv);
        int v;
        v = $urandom_range(1, nv);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // Mostly well-formed clauses over few variables, with some noise.
    task automatic push_random_mix(int beats, int nv);
        int goal, kind, n, a, b, c, code;
        logic [1:0] op;
        goal = pending_beats.size() + beats;
        while (pending_beats.size() < goal) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                n = $urandom_range(1, 3);
                a = rand_lit(nv);
                b = rand_lit(nv);
                c = rand_lit(nv);
                op = kind < 35 ? OP_ORIG : OP_LEMMA;
                push_clause(op, n, a, b, c);
                sent_clauses.insert(sent_clauses.size(),
                    (n << 12) | ((a + 8) << 8) | ((b + 8) << 4) | (c + 8));
            end else if (kind < 78 && sent_clauses.size() > 0) begin
                code = sent_clauses[$urandom_range(0, sent_clauses.size() - 1)];
                op = $urandom_range(0, 3) == 0 ? OP_LEMMA : OP_DEL;
                push_clause(op, code >> 12, ((code >> 8) & 15) - 8,
                            ((code >> 4) & 15) - 8, (code & 15) - 8);
            end else if (kind < 92) begin
                op = 2'($urandom_range(0, 2));
                push_beat(op, $urandom_range(0, 4095), $urandom_range(0, 3) != 0,
                          $urandom_range(0, 2) == 0);
            end else if (kind < 96) begin
                push_beat(OP_END, $urandom_range(0, 4095), $urandom_range(0, 1) != 0,
                          $urandom_range(0, 1) != 0);
            end else begin
                push_long_clause(OP_ORIG, $urandom_range(NLEN - 1, NLEN + 2));
            end
        end
    endtask

    // Driver: sends queued beats, holding each until it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_beat(s_data);
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                s_data <= pending_beats.pop_front();
                s_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 19);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each verdict beat and stalls the result side at random.
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("unexpected verdict, status", m_data.status, -1);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", m_data.status, want.status);
                    if (m_data.empty_derived !== want.empty_derived)
                        report_mismatch("empty_derived", m_data.empty_derived,
                                        want.empty_derived);
                end
            end
            if (stall_gap > 0) begin
                stall_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) stall_gap = $urandom_range(1, 19);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        write_limit(1024);

        // Directed clauses: propagation success and failure, deletion by set match.
        push_clause(OP_ORIG, 2, 1, 2, 0);
        push_clause(OP_ORIG, 2, -1, 3, 0);
        push_clause(OP_ORIG, 2, -2, 3, 0);
        push_clause(OP_LEMMA, 1, 3, 0, 0);
        push_clause(OP_LEMMA, 1, -3, 0, 0);
        push_clause(OP_DEL, 2, 2, 1, 0);
        push_clause(OP_DEL, 2, 1, 2, 0);
        // Error checks: duplicates, tautologies and literals out of range.
        push_clause(OP_ORIG, 2, 1, 1, 0);
        push_clause(OP_ORIG, 2, 4, -4, 0);
        push_clause(OP_ORIG, 1, 0, 0, 0);
        push_clause(OP_ORIG, 1, 1024, 0, 0);
        push_clause(OP_DEL, 1, -1024, 0, 0);
        push_clause(OP_ORIG, 1, 2047, 0, 0);
        push_clause(OP_LEMMA, 1, -2048, 0, 0);
        // Mixed opcodes in one clause: the closing beat decides.
        push_beat(OP_LEMMA, 5, 1'b1, 1'b0);
        push_beat(OP_ORIG, 6, 1'b1, 1'b1);
        // Absent literal in mid clause, then an empty original clause.
        push_beat(OP_ORIG, 7, 1'b1, 1'b0);
        push_beat(OP_ORIG, 9, 1'b0, 1'b0);
        push_beat(OP_ORIG, 8, 1'b1, 1'b1);
        push_clause(OP_ORIG, 0, 0, 0, 0);
        // End of proof in the middle of a clause clears the staging.
        push_beat(OP_ORIG, 11, 1'b1, 1'b0);
        push_beat(OP_END, -1, 1'b1, 1'b1);
        // A clause one literal too long, then one of the maximum length.
        push_long_clause(OP_ORIG, NLEN + 1);
        push_long_clause(OP_ORIG, NLEN);
        wait_idle();

        // Small and large variable limits, including zero and the lowest legal one.
        write_limit(3);
        push_clause(OP_ORIG, 1, 4, 0, 0);
        push_clause(OP_ORIG, 2, 3, -2, 0);
        wait_idle();
        write_limit(0);
        push_clause(OP_ORIG, 1, 1, 0, 0);
        push_clause(OP_LEMMA, 1, 5, 0, 0);
        wait_idle();
        write_limit(1);
        push_clause(OP_ORIG, 1, -1, 0, 0);
        push_clause(OP_ORIG, 1, 2, 0, 0);
        wait_idle();
        write_limit(2047);
        push_clause(OP_ORIG, 1, 1024, 0, 0);
        wait_idle();

        // Random clauses under the full and then a tight limit.
        write_limit(1024);
        push_random_mix(20, 6);
        wait_idle();
        write_limit(5);
        push_random_mix(15, 6);
        wait_idle();

        // Closing part without idling: derive the empty clause, then end.
        quiet = 1'b1;
        write_limit(1024);
        push_clause(OP_ORIG, 1, 900, 0, 0);
        push_clause(OP_ORIG, 1, -900, 0, 0);
        push_clause(OP_LEMMA, 0, 0, 0, 0);
        push_clause(OP_ORIG, 1, 1, 0, 0);
        push_clause(OP_DEL, 1, 900, 0, 0);
        push_beat(OP_END, 0, 1'b0, 1'b0);
        wait_idle();

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> rup_clause_proof_checker.f
+incdir+src
src/rup_pkg.sv
src/rup_front.sv
src/rup_back.sv
src/rup_clause_proof_checker.sv
dv/rup_clause_proof_checker_test.sv
